/* rtl/galg_pkg.sv */
// Shared types and constants for the axis label generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package galg_pkg;

    localparam int VAL_W   = 16;   // axis values
    localparam int PIX_W   = 12;   // pixel offsets and axis length
    localparam int LBL_W   = 6;    // max_labels register
    localparam int NUM_W   = 28;   // divider numerator
    localparam int DEN_W   = 16;   // divider denominator
    localparam int V_W     = 18;   // running label value, may pass max by one step
    localparam int CFG_W   = 12;   // configuration data width
    localparam int MAX_MIDS = 60;  // cap on labels between min and max

    typedef enum logic {
        CFG_MAX_LABELS   = 1'b0,
        CFG_PIXEL_LENGTH = 1'b1
    } t_cfg_idx;

    // candidate steps per order (10000 .. 1): 5o, 2o, o, o/2, o/5
    localparam logic [15:0] STEP_TAB [5][5] = '{
        '{16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd2000},
        '{16'd5000,  16'd2000,  16'd1000,  16'd500,  16'd200},
        '{16'd500,   16'd200,   16'd100,   16'd50,   16'd20},
        '{16'd50,    16'd20,    16'd10,    16'd5,    16'd2},
        '{16'd5,     16'd2,     16'd1,     16'd1,    16'd1}
    };

    typedef struct packed {
        logic                    err;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [VAL_W-1:0]        range;
        logic [VAL_W-1:0]        step;
        logic signed [V_W-1:0]   first;
    } t_job;

endpackage
`default_nettype wire

/* rtl/graph_axis_label_generator.sv */
// Axis label generator top level: configuration registers, job queue, front and back end.
// Depends on galg_pkg, galg_front and galg_back.
`timescale 1ns / 1ps
`default_nettype none
// An axis (min, max) transaction taken by the front end is worked through in steps
// (an error axis leaves after the check that finds it): it finds the order of the range,
// tries the candidate steps coarse to fine with one multiply and one compare for each,
// and runs the 28-bit divider for the first multiple.
// Jobs then wait in a two-entry queue for the back end, which emits min, each multiple
// (at most 60 of them) and max; every label between them is scaled by the one-bit-a-cycle
// divider, which divides (v - min) * pixel_length by the range. A range below one,
// or no step within max_labels, gives a single result with error and last set.
// Configuration writes take effect at once and are expected only while the block is idle.
module graph_axis_label_generator import galg_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [VAL_W-1:0] i_min_value,
    input  wire logic signed [VAL_W-1:0] i_max_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [VAL_W-1:0]      o_label_value,
    output logic [PIX_W-1:0]             o_pixel_offset,
    output logic                         o_error,
    output logic                         o_last
);
    logic [LBL_W-1:0] r_max_labels;
    logic [PIX_W-1:0] r_pixel_length;

    // two-entry job queue between the halves
    t_job       r_q_mem [2];
    logic       r_q_wr;
    logic       r_q_rd;
    logic [1:0] r_q_count;

    logic       w_push;
    logic       w_pop;
    t_job       w_job;
    logic       w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_labels   <= 6'd10;
            r_pixel_length <= 12'd512;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_LABELS:   r_max_labels   <= i_cfg_data[LBL_W-1:0];
                CFG_PIXEL_LENGTH: r_pixel_length <= i_cfg_data[PIX_W-1:0];
                default:          r_max_labels   <= r_max_labels;
            endcase
        end
    end

    assign w_full = (r_q_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= 1'b0;
            r_q_rd    <= 1'b0;
            r_q_count <= '0;
        end else begin
            if (w_push) begin
                r_q_mem[r_q_wr] <= w_job;
                r_q_wr          <= ~r_q_wr;
            end
            if (w_pop) r_q_rd <= ~r_q_rd;
            if (w_push && !w_pop)      r_q_count <= r_q_count + 2'd1;
            else if (w_pop && !w_push) r_q_count <= r_q_count - 2'd1;
        end
    end

    galg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_min_value (i_min_value),
        .i_max_value (i_max_value),
        .i_max_labels(r_max_labels),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    galg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (r_q_count != 2'd0),
        .i_job         (r_q_mem[r_q_rd]),
        .o_pop         (w_pop),
        .i_pixel_length(r_pixel_length),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_label_value (o_label_value),
        .o_pixel_offset(o_pixel_offset),
        .o_error       (o_error),
        .o_last        (o_last)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count != 2'd3)
        else $error("job queue overfilled");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last && o_label_value == '0 && o_pixel_offset == '0)
        else $error("malformed error result");

    a_pix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_pixel_offset <= r_pixel_length)
        else $error("pixel offset beyond axis length");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("push into full queue");
endmodule
`default_nettype wire

/* rtl/galg_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on galg_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none
module galg_div import galg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot,
    output logic [DEN_W-1:0]      o_rem
);
    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_r, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NUM_W - 1);
                r_q    <= i_num;
                r_r    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_r <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_q <= {r_q[NUM_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

/* rtl/galg_front.sv */
// Front end: takes an axis, finds its order and tick step and the first multiple.
// Depends on galg_pkg and galg_div.
`timescale 1ns / 1ps
`default_nettype none
module galg_front import galg_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [VAL_W-1:0] i_min_value,
    input  wire logic signed [VAL_W-1:0] i_max_value,
    input  wire logic [LBL_W-1:0]        i_max_labels,
    input  wire logic                    i_full,
    output logic                         o_push,
    output t_job                         o_job
);
    typedef enum logic [2:0] {
        F_IDLE, F_ORDER, F_MUL, F_TEST, F_DIV_GO, F_DIV_WAIT, F_PUSH
    } t_fstate;

    t_fstate                 r_state;
    logic signed [VAL_W-1:0] r_lo;
    logic signed [VAL_W-1:0] r_hi;
    logic signed [VAL_W:0]   r_range;
    logic [2:0]              r_k;
    logic [2:0]              r_j;
    logic [22:0]             r_prod;
    logic [VAL_W-1:0]        r_step;
    logic                    r_err;
    logic signed [V_W-1:0]   r_first;

    logic [VAL_W-1:0] w_cand;
    logic [2:0]       w_last_j;
    logic [VAL_W-1:0] w_abs;
    logic [VAL_W-1:0] w_mod;
    logic             w_done;
    logic [NUM_W-1:0] w_quot;
    logic [DEN_W-1:0] w_rem;

    assign w_cand   = STEP_TAB[r_k][r_j];
    assign w_last_j = (r_k == 3'd4) ? 3'd2 : 3'd4;
    assign w_abs    = r_lo[VAL_W-1] ? 16'(~r_lo + 16'sd1) : 16'(r_lo);
    // floor modulo from the magnitude remainder
    assign w_mod    = (!r_lo[VAL_W-1] || w_rem == '0) ? w_rem : r_step - w_rem;

    galg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == F_DIV_GO),
        .i_num  (NUM_W'(w_abs)),
        .i_den  (r_step),
        .o_done (w_done),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_lo    <= i_min_value;
                        r_hi    <= i_max_value;
                        r_range <= {i_max_value[VAL_W-1], i_max_value}
                                 - {i_min_value[VAL_W-1], i_min_value};
                        r_err   <= 1'b0;
                        r_state <= F_ORDER;
                    end
                end
                F_ORDER: begin
                    r_j <= '0;
                    if (r_range[VAL_W] || r_range == '0) begin
                        r_err   <= 1'b1;
                        r_state <= F_PUSH;
                    end else begin
                        if (r_range >= 17'sd10000)     r_k <= 3'd0;
                        else if (r_range >= 17'sd1000) r_k <= 3'd1;
                        else if (r_range >= 17'sd100)  r_k <= 3'd2;
                        else if (r_range >= 17'sd10)   r_k <= 3'd3;
                        else                           r_k <= 3'd4;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_prod  <= 23'(w_cand) * 23'({1'b0, i_max_labels} + 7'd1);
                    r_state <= F_TEST;
                end
                F_TEST: begin
                    // too many steps when range >= step * (max_labels + 1)
                    if ({7'd0, r_range[VAL_W-1:0]} >= r_prod) begin
                        if (r_j == '0) begin
                            r_err   <= 1'b1;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_DIV_GO;
                        end
                    end else begin
                        r_step <= w_cand;
                        if (r_j == w_last_j) begin
                            r_state <= F_DIV_GO;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= F_MUL;
                        end
                    end
                end
                F_DIV_GO: begin
                    r_state <= F_DIV_WAIT;
                end
                F_DIV_WAIT: begin
                    if (w_done) begin
                        r_first <= V_W'(r_lo) - V_W'(signed'({2'b00, w_mod}))
                                 + V_W'(signed'({2'b00, r_step}));
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_job.err   = r_err;
    assign o_job.lo    = r_lo;
    assign o_job.hi    = r_hi;
    assign o_job.range = r_range[VAL_W-1:0];
    assign o_job.step  = r_step;
    assign o_job.first = r_first;
endmodule
`default_nettype wire

/* rtl/galg_back.sv */
// Back end: walks the tick multiples of a job and emits the label transactions.
// Depends on galg_pkg and galg_div.
`timescale 1ns / 1ps
`default_nettype none
module galg_back import galg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    input  wire logic [PIX_W-1:0] i_pixel_length,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [VAL_W-1:0]      o_label_value,
    output logic [PIX_W-1:0]      o_pixel_offset,
    output logic                  o_error,
    output logic                  o_last
);
    typedef enum logic [3:0] {
        B_IDLE, B_ERR, B_FIRST, B_CHECK, B_MUL, B_DIV_GO, B_DIV_WAIT, B_EMIT, B_LAST
    } t_bstate;

    t_bstate               r_state;
    t_job                  r_job;
    logic signed [V_W-1:0] r_v;
    logic [5:0]            r_cnt;
    logic [NUM_W-1:0]      r_prod;
    logic [PIX_W-1:0]      r_quot;
    logic                  r_ov;
    logic [VAL_W-1:0]      r_label;
    logic [PIX_W-1:0]      r_off;
    logic                  r_err;
    logic                  r_last;

    logic                  w_slot;
    logic                  w_emit;
    logic [VAL_W-1:0]      w_diff;
    logic signed [V_W-1:0] w_hi;
    logic                  w_done;
    logic [NUM_W-1:0]      w_quot;
    logic [DEN_W-1:0]      w_rem;

    assign w_slot = !r_ov || i_out_ready;
    // a label is loaded into the output register this cycle
    assign w_emit = w_slot && (r_state == B_ERR || r_state == B_FIRST
                               || r_state == B_EMIT || r_state == B_LAST);
    assign w_hi   = V_W'(r_job.hi);
    assign w_diff = VAL_W'(r_v - V_W'(r_job.lo));

    galg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == B_DIV_GO),
        .i_num  (r_prod),
        .i_den  (r_job.range),
        .o_done (w_done),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= w_emit || (r_ov && !i_out_ready);
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= i_job.err ? B_ERR : B_FIRST;
                    end
                end
                B_ERR: begin
                    if (w_slot) begin
                        r_label <= '0; r_off <= '0;
                        r_err <= 1'b1; r_last <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                B_FIRST: begin
                    if (w_slot) begin
                        r_label <= r_job.lo; r_off <= '0;
                        r_err <= 1'b0; r_last <= 1'b0;
                        r_v   <= r_job.first;
                        r_cnt <= '0;
                        r_state <= B_CHECK;
                    end
                end
                B_CHECK: begin
                    if (r_v < w_hi && r_cnt < 6'(MAX_MIDS)) r_state <= B_MUL;
                    else                                     r_state <= B_LAST;
                end
                B_MUL: begin
                    r_prod  <= NUM_W'(w_diff) * NUM_W'(i_pixel_length);
                    r_state <= B_DIV_GO;
                end
                B_DIV_GO: r_state <= B_DIV_WAIT;
                B_DIV_WAIT: begin
                    if (w_done) begin
                        r_quot  <= w_quot[PIX_W-1:0];
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (w_slot) begin
                        r_label <= r_v[VAL_W-1:0]; r_off <= r_quot;
                        r_err <= 1'b0; r_last <= 1'b0;
                        r_v   <= r_v + V_W'(signed'({2'b00, r_job.step}));
                        r_cnt <= r_cnt + 6'd1;
                        r_state <= B_CHECK;
                    end
                end
                B_LAST: begin
                    if (w_slot) begin
                        r_label <= r_job.hi; r_off <= i_pixel_length;
                        r_err <= 1'b0; r_last <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop          = (r_state == B_IDLE) && i_job_valid;
    assign o_out_valid    = r_ov;
    assign o_label_value  = r_label;
    assign o_pixel_offset = r_off;
    assign o_error        = r_err;
    assign o_last         = r_last;
endmodule
`default_nettype wire
